// ===== rtl/rmi_pkg.sv =====
package rmi_pkg;

  localparam int unsigned DelayCountBitsDef = 16;

  localparam int unsigned RefW    = 16;
  localparam int unsigned DutyW   = 8;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [15:0] DeadBandRst       = 16'd1638;
  localparam logic [15:0] ReverseDelayRst   = 16'd500;
  localparam logic [15:0] MotorGainRst      = 16'd40960;
  localparam logic [7:0]  MotorOffsetRst    = 8'd0;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_REF   = 2'd1,
    ACT_BRAKE = 2'd2
  } rmi_action_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEAD_BAND     = 2'd0,
    CFG_REVERSE_DELAY = 2'd1,
    CFG_GAIN          = 2'd2,
    CFG_MOTOR_OFFSET  = 2'd3
  } rmi_cfg_idx_e;

  typedef struct packed {
    logic [15:0] dead_band;
    logic [15:0] lockout_ticks;
    logic [15:0] scale_gain;
    logic [7:0]  motor_offset;
  } rmi_cfg_t;

  typedef struct packed {
    logic [DutyW-1:0] throttle_duty;
    logic             reverse_out;
    logic [DutyW-1:0] brake_duty;
    logic             held;
  } rmi_res_t;

endpackage

// ===== rtl/motor_reversal_interlock_throttle.sv =====
// an accepted input passes through the input register, then the result register
// one item per cycle when not stalled; state updates as an item enters the result register
// in_stall_o rises only while the input register is full and a waiting result is stalled
// reset clears direction, lockout counter, throttle and brake levels and all valid flags
// config registers reset to their defaults; the block is locked out until enough ticks pass
module motor_reversal_interlock_throttle #(
  parameter int unsigned DELAY_COUNT_BITS = rmi_pkg::DelayCountBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  action_i,
  input  logic signed [15:0]          reference_i,
  input  logic [7:0]                  brake_level_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [7:0]                  throttle_duty_o,
  output logic                        reverse_out_o,
  output logic [7:0]                  brake_duty_o,
  output logic                        held_o,
  input  logic                        cfg_we_i,
  input  logic [rmi_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [rmi_pkg::CfgW-1:0]    cfg_data_i
);

  rmi_pkg::rmi_cfg_t cfg;
  rmi_pkg::rmi_res_t res, out_q;

  logic        s1_valid_q;
  logic [1:0]  s1_action_q;
  logic [15:0] s1_ref_q;
  logic [7:0]  s1_brake_q;
  logic        out_valid_q;
  logic        pipe_en, fire, in_take;

  assign pipe_en    = !out_valid_q || !out_stall_i;
  assign fire       = s1_valid_q && pipe_en;
  assign in_stall_o = s1_valid_q && !pipe_en;
  assign in_take    = in_valid_i && !in_stall_o;

  rmi_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  rmi_core #(
    .DELAY_COUNT_BITS (DELAY_COUNT_BITS)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .fire_i        (fire),
    .action_i      (s1_action_q),
    .reference_i   (s1_ref_q),
    .brake_level_i (s1_brake_q),
    .res_o         (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (pipe_en) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_action_q <= action_i;
      s1_ref_q    <= reference_i;
      s1_brake_q  <= brake_level_i;
    end
    if (fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign throttle_duty_o = out_q.throttle_duty;
  assign reverse_out_o   = out_q.reverse_out;
  assign brake_duty_o    = out_q.brake_duty;
  assign held_o          = out_q.held;

  // a refused reference never carries throttle
  a_held_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.held) |-> out_q.throttle_duty == '0)
    else $error("held result with nonzero throttle");

  // input side only backs up behind a stalled full result register
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_q && out_stall_i && s1_valid_q))
    else $error("input stalled without a blocked result");

  // a stalled result item stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(out_q)))
    else $error("stalled result changed");

endmodule

// ===== rtl/rmi_cfg.sv =====
module rmi_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [rmi_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [rmi_pkg::CfgW-1:0]    cfg_data_i,
  output rmi_pkg::rmi_cfg_t           cfg_o
);

  rmi_pkg::rmi_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (rmi_pkg::rmi_cfg_idx_e'(cfg_idx_i))
        rmi_pkg::CFG_DEAD_BAND:     cfg_d.dead_band     = cfg_data_i;
        rmi_pkg::CFG_REVERSE_DELAY: cfg_d.lockout_ticks = cfg_data_i;
        rmi_pkg::CFG_GAIN:          cfg_d.scale_gain    = cfg_data_i;
        rmi_pkg::CFG_MOTOR_OFFSET:  cfg_d.motor_offset  = cfg_data_i[7:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dead_band     <= rmi_pkg::DeadBandRst;
      cfg_q.lockout_ticks <= rmi_pkg::ReverseDelayRst;
      cfg_q.scale_gain    <= rmi_pkg::MotorGainRst;
      cfg_q.motor_offset  <= rmi_pkg::MotorOffsetRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/rmi_core.sv =====
module rmi_core #(
  parameter int unsigned DELAY_COUNT_BITS = rmi_pkg::DelayCountBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rmi_pkg::rmi_cfg_t           cfg_i,
  input  logic                        fire_i,
  input  logic [1:0]                  action_i,
  input  logic [rmi_pkg::RefW-1:0]    reference_i,
  input  logic [rmi_pkg::DutyW-1:0]   brake_level_i,
  output rmi_pkg::rmi_res_t           res_o
);

  localparam int unsigned CmpW = (DELAY_COUNT_BITS > 16) ? DELAY_COUNT_BITS : 16;

  logic                        rev_q, rev_d;
  logic [DELAY_COUNT_BITS-1:0] cnt_q, cnt_d;
  logic [7:0]                  thr_lvl_q, thr_lvl_d;
  logic [7:0]                  brk_q, brk_d;
  logic                        held;

  logic [17:0] ref_x, thr_x, neg_thr, ref_neg;
  logic [16:0] mag;
  logic        flip_fwd, flip_rev, flip;
  logic [DELAY_COUNT_BITS-1:0] cnt_eff;
  logic        locked;
  logic [32:0] prod;
  logic [10:0] sum;
  logic [7:0]  scaled_sat;

  // sign-extended reference and threshold compares
  assign ref_x    = {{2{reference_i[15]}}, reference_i};
  assign thr_x    = {2'b00, cfg_i.dead_band};
  assign neg_thr  = 18'd0 - thr_x;
  assign ref_neg  = 18'd0 - ref_x;
  assign mag      = ref_x[17] ? ref_neg[16:0] : ref_x[16:0];
  assign flip_fwd = !rev_q && ($signed(ref_x) < $signed(neg_thr));
  assign flip_rev = rev_q && ($signed(ref_x) > $signed(thr_x));
  assign flip     = flip_fwd || flip_rev;

  assign cnt_eff  = flip ? '0 : cnt_q;
  assign locked   = CmpW'(cnt_eff) < CmpW'(cfg_i.lockout_ticks);

  // gain q8.8 times magnitude q0.15, shift drops 23 fraction bits
  assign prod       = {17'd0, cfg_i.scale_gain} * {16'd0, mag};
  assign sum        = {1'b0, prod[32:23]} + {3'd0, cfg_i.motor_offset};
  assign scaled_sat = (|sum[10:8]) ? 8'hFF : sum[7:0];

  always_comb begin
    rev_d     = rev_q;
    cnt_d     = cnt_q;
    thr_lvl_d = thr_lvl_q;
    brk_d     = brk_q;
    held      = 1'b0;
    unique case (rmi_pkg::rmi_action_e'(action_i))
      rmi_pkg::ACT_TICK: begin
        if (cnt_q != {DELAY_COUNT_BITS{1'b1}}) begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      rmi_pkg::ACT_REF: begin
        if (flip) begin
          rev_d = !rev_q;
        end
        cnt_d = cnt_eff;
        if (locked) begin
          thr_lvl_d = '0;
          held      = 1'b1;
        end else if (mag < {1'b0, cfg_i.dead_band}) begin
          thr_lvl_d = '0;
        end else begin
          thr_lvl_d = scaled_sat;
        end
      end
      rmi_pkg::ACT_BRAKE: brk_d = brake_level_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rev_q     <= 1'b0;
      cnt_q     <= '0;
      thr_lvl_q <= '0;
      brk_q     <= '0;
    end else if (fire_i) begin
      rev_q     <= rev_d;
      cnt_q     <= cnt_d;
      thr_lvl_q <= thr_lvl_d;
      brk_q     <= brk_d;
    end
  end

  assign res_o.throttle_duty = thr_lvl_d;
  assign res_o.reverse_out   = rev_d;
  assign res_o.brake_duty    = brk_d;
  assign res_o.held          = held;

  // a direction change always restarts the lockout counter
  a_flip_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(rev_q) |-> cnt_q == '0)
    else $error("direction changed without counter restart");

  // counter only moves up by one or back to zero
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!$stable(cnt_q) && cnt_q != '0) |-> cnt_q == DELAY_COUNT_BITS'($past(cnt_q) + 1'b1))
    else $error("lockout counter jumped");

  // nonzero throttle only after lockout has expired
  a_lockout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && held) |=> thr_lvl_q == '0)
    else $error("throttle driven during lockout");

endmodule
